// ----- rtl/dfa_pkg.sv -----
// shared types and constants for the table-driven automaton stepper
// no dependencies
`default_nettype none

package dfa_pkg;

	localparam int CMD_W   = 3;
	localparam int STATE_W = 6;
	localparam int SYM_W   = 8;

	localparam logic [CMD_W-1:0] CMD_SEND        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CONNECT     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FALLBACK    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ACCEPT      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SET_CURRENT = 3'd4;

	// one entry of the transition memory
	typedef struct packed {
		logic               valid;
		logic [STATE_W-1:0] target;
	} trans_ent_t;

	// one entry of the per-state memory
	typedef struct packed {
		logic               accept;
		logic               fb_valid;
		logic [STATE_W-1:0] fb_target;
	} state_ent_t;

endpackage

`default_nettype wire

// ----- rtl/dfa_ram.sv -----
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`default_nettype none

module dfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/table_driven_dfa_stepper_top.sv -----
// Programmable automaton stepper. After reset the block runs a clearing pass over
// the transition memory and the per-state memory, with in_ready low. Every beat
// then goes through a read of both memories at acceptance, a step to decide and
// write back, a read of the per-state memory at the new current state for its
// accept mark, and the load of the result register. The block holds one beat at
// a time, so it takes no new item until the last one's result is loaded; a
// result waiting on out_ready stalls only the next item's final load step.
// Depends on dfa_pkg and dfa_ram.
`default_nettype none

module table_driven_dfa_stepper_top #(
	parameter int NUM_STATES  = 64,
	parameter int SYMBOL_BITS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic [dfa_pkg::CMD_W-1:0]   cmd,
	input  wire logic [dfa_pkg::STATE_W-1:0] from_state,
	input  wire logic [dfa_pkg::SYM_W-1:0]   symbol,
	input  wire logic [dfa_pkg::STATE_W-1:0] to_state,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [dfa_pkg::STATE_W-1:0] current_state,
	output      logic                        accepting,
	output      logic                        no_move_error
);

	localparam int STW      = $clog2(NUM_STATES);
	localparam int ADDR_W   = STW + SYMBOL_BITS;
	localparam int TDEPTH   = NUM_STATES * (1 << SYMBOL_BITS);
	localparam int TWIDTH   = $bits(dfa_pkg::trans_ent_t);
	localparam int SWIDTH   = $bits(dfa_pkg::state_ent_t);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(TDEPTH - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_RD,
		S_FIN
	} state_t;

	state_t                        state_q;
	logic [ADDR_W-1:0]             clr_q;
	logic [dfa_pkg::CMD_W-1:0]     cmd_q;
	logic [dfa_pkg::STATE_W-1:0]   from_q;
	logic [dfa_pkg::STATE_W-1:0]   to_q;
	logic [SYMBOL_BITS-1:0]        sym_q;
	logic [dfa_pkg::STATE_W-1:0]   cur_q;
	logic                          err_q;
	logic                          out_valid_q;
	logic [dfa_pkg::STATE_W-1:0]   current_state_q;
	logic                          accepting_q;
	logic                          no_move_error_q;

	logic [SYMBOL_BITS-1:0]        in_sym;
	logic [STW-1:0]                in_from_idx;
	logic [STW-1:0]                from_idx_q;
	logic [STW-1:0]                cur_idx;
	logic                          from_ok;
	logic                          to_ok;
	logic                          out_load;

	dfa_pkg::trans_ent_t           t_rd;
	dfa_pkg::trans_ent_t           t_wr_data;
	logic                          t_wr_en;
	logic [ADDR_W-1:0]             t_wr_addr;
	logic [ADDR_W-1:0]             t_rd_addr;

	dfa_pkg::state_ent_t           s_rd;
	dfa_pkg::state_ent_t           s_wr_data;
	logic                          s_wr_en;
	logic [STW-1:0]                s_wr_addr;
	logic [STW-1:0]                s_rd_addr;

	logic [dfa_pkg::STATE_W-1:0]   send_next;
	logic                          send_err;

	assign in_sym      = SYMBOL_BITS'(32'(symbol));
	assign in_from_idx = STW'(32'(from_state));
	assign from_idx_q  = STW'(32'(from_q));
	assign cur_idx     = STW'(32'(cur_q));
	assign from_ok     = 32'(from_q) < 32'(NUM_STATES);
	assign to_ok       = 32'(to_q) < 32'(NUM_STATES);

	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// explicit transition first, then the state's fallback, else stay put and flag an error
	always_comb begin
		send_err = 1'b0;
		if (t_rd.valid) begin
			send_next = t_rd.target;
		end else if (s_rd.fb_valid) begin
			send_next = s_rd.fb_target;
		end else begin
			send_next = cur_q;
			send_err  = 1'b1;
		end
	end

	// memory port control
	always_comb begin
		if (cmd == dfa_pkg::CMD_SEND) begin
			t_rd_addr = {cur_idx, in_sym};
		end else begin
			t_rd_addr = {in_from_idx, in_sym};
		end

		if (state_q != S_IDLE || cmd == dfa_pkg::CMD_SEND) begin
			s_rd_addr = cur_idx;
		end else begin
			s_rd_addr = in_from_idx;
		end

		t_wr_en   = 1'b0;
		t_wr_addr = {from_idx_q, sym_q};
		t_wr_data = '{valid: 1'b1, target: to_q};
		s_wr_en   = 1'b0;
		s_wr_addr = from_idx_q;
		s_wr_data = s_rd;

		if (state_q == S_CLEAR) begin
			t_wr_en   = 1'b1;
			t_wr_addr = clr_q;
			t_wr_data = '0;
			s_wr_en   = clr_q < ADDR_W'(NUM_STATES);
			s_wr_addr = clr_q[STW-1:0];
			s_wr_data = '0;
		end else if (state_q == S_LOOK) begin
			case (cmd_q)
				dfa_pkg::CMD_CONNECT: begin
					t_wr_en = from_ok && to_ok;
				end
				dfa_pkg::CMD_FALLBACK: begin
					s_wr_en   = from_ok && to_ok;
					s_wr_data = '{accept: s_rd.accept, fb_valid: 1'b1, fb_target: to_q};
				end
				dfa_pkg::CMD_ACCEPT: begin
					s_wr_en   = from_ok;
					s_wr_data = '{accept: 1'b1, fb_valid: s_rd.fb_valid,
						fb_target: s_rd.fb_target};
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_q           <= '0;
			cmd_q           <= '0;
			from_q          <= '0;
			to_q            <= '0;
			sym_q           <= '0;
			cur_q           <= '0;
			err_q           <= 1'b0;
			out_valid_q     <= 1'b0;
			current_state_q <= '0;
			accepting_q     <= 1'b0;
			no_move_error_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						from_q  <= from_state;
						to_q    <= to_state;
						sym_q   <= in_sym;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					err_q <= (cmd_q == dfa_pkg::CMD_SEND) ? send_err : 1'b0;
					case (cmd_q)
						dfa_pkg::CMD_SEND: begin
							cur_q <= send_next;
						end
						dfa_pkg::CMD_SET_CURRENT: begin
							if (from_ok) begin
								cur_q <= from_q;
							end
						end
						default: begin
						end
					endcase
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						current_state_q <= cur_q;
						accepting_q     <= s_rd.accept;
						no_move_error_q <= err_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	dfa_ram #(
		.WIDTH (TWIDTH),
		.DEPTH (TDEPTH)
	) u_trans_ram (
		.clk     (clk),
		.wr_en   (t_wr_en),
		.wr_addr (t_wr_addr),
		.wr_data (t_wr_data),
		.rd_addr (t_rd_addr),
		.rd_data (t_rd)
	);

	dfa_ram #(
		.WIDTH (SWIDTH),
		.DEPTH (NUM_STATES)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (s_wr_en),
		.wr_addr (s_wr_addr),
		.wr_data (s_wr_data),
		.rd_addr (s_rd_addr),
		.rd_data (s_rd)
	);

	assign out_valid     = out_valid_q;
	assign current_state = current_state_q;
	assign accepting     = accepting_q;
	assign no_move_error = no_move_error_q;

endmodule

`default_nettype wire

// ----- rtl/dfa_chk.sv -----
// port-level checks for the automaton stepper, bound to the top level
// depends on dfa_pkg and table_driven_dfa_stepper_top
`default_nettype none

module dfa_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [dfa_pkg::STATE_W-1:0] current_state,
	input wire logic                        accepting,
	input wire logic                        no_move_error
);

	// one beat in flight: ready drops right after a beat is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after a beat was taken");

	// a fresh result only follows a cycle in which the block was busy
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(current_state)
			&& $stable(accepting) && $stable(no_move_error))
		else $error("stalled result changed");

endmodule

bind table_driven_dfa_stepper_top dfa_chk u_dfa_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.current_state (current_state),
	.accepting     (accepting),
	.no_move_error (no_move_error)
);

`default_nettype wire

// ----- test/table_driven_dfa_stepper_top_tb.sv -----
// self-checking bench for the table-driven automaton stepper: directed loads and sends,
// then random automata built and walked, first under sender and receiver stalls, then with none
// depends on dfa_pkg and table_driven_dfa_stepper_top
`timescale 1ns / 1ps

module table_driven_dfa_stepper_top_tb;

	localparam int N_STATES    = 64;
	localparam int N_SYM_BITS  = 8;
	localparam int N_SYMBOLS   = 1 << N_SYM_BITS;
	localparam int TABLE_DEPTH = N_STATES * N_SYMBOLS;
	localparam int ITEMS_PER_PHASE = 430;
	localparam int STALL_LIMIT = 60000;
	localparam int MAX_REPORTS = 10;

	localparam logic [dfa_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
	localparam logic [dfa_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [dfa_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [dfa_pkg::STATE_W-1:0] state;
		logic                        acc;
		logic                        err;
	} dfa_result_t;

	class dfa_shadow;
		bit [dfa_pkg::STATE_W-1:0] cur;
		bit [dfa_pkg::STATE_W-1:0] next_tgt [TABLE_DEPTH];
		bit                        next_ok  [TABLE_DEPTH];
		bit [dfa_pkg::STATE_W-1:0] fb_tgt   [N_STATES];
		bit                        fb_ok    [N_STATES];
		bit                        acc_mark [N_STATES];
		dfa_result_t               pending_results [$];
		int                        mismatches;

		function int table_index(int st, logic [dfa_pkg::SYM_W-1:0] sym);
			return st * N_SYMBOLS + (int'(sym) & (N_SYMBOLS - 1));
		endfunction

		function void apply_item(logic [dfa_pkg::CMD_W-1:0] c,
				logic [dfa_pkg::STATE_W-1:0] from, logic [dfa_pkg::SYM_W-1:0] sym,
				logic [dfa_pkg::STATE_W-1:0] to);
			int          idx;
			bit          err;
			dfa_result_t r;
			err = 1'b0;
			case (c)
				dfa_pkg::CMD_SEND: begin
					idx = table_index(cur, sym);
					if (next_ok[idx])
						cur = next_tgt[idx];
					else if (fb_ok[cur])
						cur = fb_tgt[cur];
					else
						err = 1'b1;
				end
				dfa_pkg::CMD_CONNECT: begin
					if (from < N_STATES && to < N_STATES) begin
						idx = table_index(from, sym);
						next_tgt[idx] = to;
						next_ok[idx]  = 1'b1;
					end
				end
				dfa_pkg::CMD_FALLBACK: begin
					if (from < N_STATES && to < N_STATES) begin
						fb_tgt[from] = to;
						fb_ok[from]  = 1'b1;
					end
				end
				dfa_pkg::CMD_ACCEPT: begin
					if (from < N_STATES)
						acc_mark[from] = 1'b1;
				end
				dfa_pkg::CMD_SET_CURRENT: begin
					if (from < N_STATES)
						cur = from;
				end
				default: ;
			endcase
			r.state = cur;
			r.acc   = acc_mark[cur];
			r.err   = err;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [dfa_pkg::STATE_W-1:0] st, logic acc, logic err);
			dfa_result_t got;
			dfa_result_t exp_r;
			got.state = st;
			got.acc   = acc;
			got.err   = err;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t unexpected result beat: state %0d acc %0b err %0b",
						$time, st, acc, err);
				return;
			end
			exp_r = pending_results.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t mismatch: state %0d/%0d acc %0b/%0b err %0b/%0b (exp/got)",
						$time, exp_r.state, st, exp_r.acc, acc, exp_r.err, err);
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [dfa_pkg::CMD_W-1:0]   cmd = '0;
	logic [dfa_pkg::STATE_W-1:0] from_state = '0;
	logic [dfa_pkg::SYM_W-1:0]   symbol = '0;
	logic [dfa_pkg::STATE_W-1:0] to_state = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [dfa_pkg::STATE_W-1:0] current_state;
	logic                        accepting;
	logic                        no_move_error;

	int        send_idle_pct = 33;
	int        recv_idle_pct = 52;
	int        quiet_cycles = 0;
	dfa_shadow shadow = new();

	table_driven_dfa_stepper_top #(
		.NUM_STATES(N_STATES),
		.SYMBOL_BITS(N_SYM_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.from_state(from_state),
		.symbol(symbol),
		.to_state(to_state),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.current_state(current_state),
		.accepting(accepting),
		.no_move_error(no_move_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// both channels observed at the rising edge, input noted before the result check
	always @(posedge clk) begin
		if (in_valid && in_ready)
			shadow.apply_item(cmd, from_state, symbol, to_state);
		if (out_valid && out_ready)
			shadow.check_result(current_state, accepting, no_move_error);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// entered and left at a falling edge
	task automatic drive_item(input logic [dfa_pkg::CMD_W-1:0] c,
			input logic [dfa_pkg::STATE_W-1:0] f, input logic [dfa_pkg::SYM_W-1:0] s,
			input logic [dfa_pkg::STATE_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		cmd        = c;
		from_state = f;
		symbol     = s;
		to_state   = t;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic [dfa_pkg::STATE_W-1:0] pick_state();
		if ($urandom_range(99) < 80)
			return dfa_pkg::STATE_W'($urandom_range(0, 5));
		return dfa_pkg::STATE_W'($urandom_range(0, N_STATES - 1));
	endfunction

	function automatic logic [dfa_pkg::SYM_W-1:0] pick_symbol();
		if ($urandom_range(99) < 80)
			return dfa_pkg::SYM_W'($urandom_range(0, 3));
		return dfa_pkg::SYM_W'($urandom_range(0, N_SYMBOLS - 1));
	endfunction

	// mostly small automata that get walked, with some wide-range noise
	task automatic drive_random_item();
		int                        pick;
		logic [dfa_pkg::CMD_W-1:0] c;
		pick = $urandom_range(99);
		if (pick < 45)
			c = dfa_pkg::CMD_SEND;
		else if (pick < 65)
			c = dfa_pkg::CMD_CONNECT;
		else if (pick < 75)
			c = dfa_pkg::CMD_FALLBACK;
		else if (pick < 83)
			c = dfa_pkg::CMD_ACCEPT;
		else if (pick < 93)
			c = dfa_pkg::CMD_SET_CURRENT;
		else if (pick < 95)
			c = CMD_SPARE_5;
		else if (pick < 97)
			c = CMD_SPARE_6;
		else
			c = CMD_SPARE_7;
		drive_item(c, pick_state(), pick_symbol(), pick_state());
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: no move from reset, spare codes, extremes, overwrites, fallback paths
		drive_item(dfa_pkg::CMD_SEND, 6'd0, 8'd0, 6'd0);
		drive_item(CMD_SPARE_5, 6'd17, 8'd170, 6'd42);
		drive_item(CMD_SPARE_6, 6'd0, 8'd0, 6'd0);
		drive_item(CMD_SPARE_7, 6'd63, 8'd255, 6'd63);
		drive_item(dfa_pkg::CMD_ACCEPT, 6'd63, 8'd0, 6'd0);
		drive_item(dfa_pkg::CMD_SET_CURRENT, 6'd63, 8'd0, 6'd0);
		drive_item(dfa_pkg::CMD_SEND, 6'd0, 8'd255, 6'd0);
		drive_item(dfa_pkg::CMD_CONNECT, 6'd63, 8'd255, 6'd0);
		drive_item(dfa_pkg::CMD_CONNECT, 6'd63, 8'd255, 6'd5);
		drive_item(dfa_pkg::CMD_SEND, 6'd0, 8'd255, 6'd0);
		drive_item(dfa_pkg::CMD_FALLBACK, 6'd5, 8'd0, 6'd63);
		drive_item(dfa_pkg::CMD_FALLBACK, 6'd5, 8'd0, 6'd0);
		drive_item(dfa_pkg::CMD_SEND, 6'd0, 8'd0, 6'd0);
		drive_item(dfa_pkg::CMD_CONNECT, 6'd0, 8'd0, 6'd63);
		drive_item(dfa_pkg::CMD_SEND, 6'd0, 8'd0, 6'd0);
		drive_item(dfa_pkg::CMD_CONNECT, 6'd63, 8'd0, 6'd63);
		drive_item(dfa_pkg::CMD_SEND, 6'd0, 8'd0, 6'd0);
		drive_item(dfa_pkg::CMD_FALLBACK, 6'd63, 8'd0, 6'd63);
		drive_item(dfa_pkg::CMD_SEND, 6'd0, 8'd1, 6'd0);
		drive_item(dfa_pkg::CMD_SET_CURRENT, 6'd0, 8'd255, 6'd63);
		drive_item(dfa_pkg::CMD_ACCEPT, 6'd0, 8'd0, 6'd0);
		drive_item(dfa_pkg::CMD_SEND, 6'd0, 8'd0, 6'd0);
		drive_item(dfa_pkg::CMD_SEND, 6'd0, 8'd128, 6'd0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 33;
					recv_idle_pct = 52;
				end
				1: begin
					send_idle_pct = 52;
					recv_idle_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (ITEMS_PER_PHASE) drive_random_item();
		end
		in_valid = 1'b0;

		while (shadow.pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (shadow.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/dfa_pkg.sv
rtl/dfa_ram.sv
rtl/table_driven_dfa_stepper_top.sv
rtl/dfa_chk.sv
test/table_driven_dfa_stepper_top_tb.sv
